### design/rv32ex_pkg.sv
`default_nettype none

package rv32ex_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned SHAMT_W = 5;

  // instruction class, as decoded upstream
  typedef enum logic [3:0] {
    FN_LOAD   = 4'd0,
    FN_OPIMM  = 4'd1,
    FN_AUIPC  = 4'd2,
    FN_STORE  = 4'd3,
    FN_OP     = 4'd4,
    FN_LUI    = 4'd5,
    FN_BRANCH = 4'd6,
    FN_JALR   = 4'd7,
    FN_JAL    = 4'd8,
    FN_FENCE  = 4'd9,
    FN_SYSTEM = 4'd10
  } func_t;

  typedef enum logic [2:0] {
    SYS_EBREAK  = 3'd0,
    SYS_ECALL   = 3'd1,
    SYS_SRET    = 3'd2,
    SYS_MRET    = 3'd3,
    SYS_WFI     = 3'd4,
    SYS_CSR     = 3'd5,
    SYS_INVALID = 3'd6
  } sys_op_t;

  typedef enum logic [2:0] {
    ST_NORMAL  = 3'd0,
    ST_BREAK   = 3'd1,
    ST_ECALL   = 3'd2,
    ST_TRET    = 3'd3,
    ST_WFI     = 3'd4,
    ST_ILLEGAL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MW_BYTE = 2'd0,
    MW_HALF = 2'd1,
    MW_WORD = 2'd2
  } mem_width_t;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // load / store funct3
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

  typedef struct packed {
    logic [3:0]      func;
    logic [2:0]      sys_op;
    logic [2:0]      funct3;
    logic            alt_bit;
    logic [XLEN-1:0] rs1_value;
    logic [XLEN-1:0] rs2_value;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] pc;
  } op_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic [1:0]      mem_width;
    logic            mem_signed;
    logic            branch_taken;
    logic [XLEN-1:0] branch_target;
    logic [2:0]      status;
  } res_t;

  // ALU value and compare flags handed to the control block
  typedef struct packed {
    logic [XLEN-1:0] y;
    logic            eq;
    logic            lt;
    logic            ltu;
  } alu_out_t;

endpackage

`default_nettype wire

### design/rv32i_execute_stage.sv
`default_nettype none

// RV32I execute stage.
//
// Operand channel (op_valid / op_ready / op): one beat per decoded instruction,
// carrying class, system subop, funct3, bit 30, both register values, the
// immediate and the pc.
// Result channel (res_valid / res_ready / res): one beat per instruction with
// the ALU value, address, link address, pc-relative sum or immediate, access
// width and signedness, branch decision and target, and a status code.
//
// An accepted beat sits in the operand register while the decode, ALU and
// adders act on it, and then moves into the result register that drives the
// outputs. Throughput is one beat per cycle while res_ready is high; the
// operand register keeps accepting while the result register still holds a
// beat the receiver has not taken, and stops only when both are full.
// With res_ready low the result beat holds and op_ready falls once the operand
// register is also occupied. Reset empties both registers; the block has no
// other state.
module rv32i_execute_stage (
  input  wire               clk,
  input  wire               rst,
  input  wire               op_valid,
  output logic              op_ready,
  input  rv32ex_pkg::op_t   op,
  output logic              res_valid,
  input  wire               res_ready,
  output rv32ex_pkg::res_t  res
);
  import rv32ex_pkg::*;

  op_t      op_q;
  logic     op_q_valid;
  alu_out_t alu;
  res_t     res_next;
  logic     adv;

  // operand register moves whenever the result register can take its beat
  assign op_ready = !op_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q_valid <= 1'b0;
    end else if (op_ready) begin
      op_q_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      op_q <= op;
    end
  end

  rv32ex_alu u_alu (
    .op  (op_q),
    .alu (alu)
  );

  rv32ex_ctrl u_ctrl (
    .op  (op_q),
    .alu (alu),
    .res (res_next)
  );

  rv32ex_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (op_q_valid),
    .res_next  (res_next),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (adv)
  );

  // an accepted beat always lands in the operand register
  a_op_capture: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> op_q_valid)
    else $error("accepted operand beat not held");

  // a held operand beat moves on whenever the result register has room
  a_op_advance: assert property (@(posedge clk) disable iff (rst)
    op_q_valid && adv |=> res_valid)
    else $error("operand beat lost on the way to the result register");

  // redirects come only from well-formed control transfers
  a_taken_normal: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.branch_taken |-> res.status == ST_NORMAL)
    else $error("taken branch with a trap status");

  // an illegal instruction leaves the result, branch flag and branch target at zero
  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_ILLEGAL |->
      res.result == '0 && !res.branch_taken && res.branch_target == '0)
    else $error("illegal instruction with live result fields");

endmodule

`default_nettype wire

### design/rv32ex_alu.sv
`default_nettype none

module rv32ex_alu (
  input  rv32ex_pkg::op_t      op,
  output rv32ex_pkg::alu_out_t alu
);
  import rv32ex_pkg::*;

  logic [XLEN-1:0]    a;
  logic [XLEN-1:0]    b;
  logic               use_rs2;
  logic               sub_en;
  logic [SHAMT_W-1:0] shamt;
  logic [XLEN-1:0]    sum;
  logic [XLEN:0]      sr_ext;
  logic [XLEN-1:0]    y;
  logic               eq;
  logic               lt;
  logic               ltu;

  // register-register forms and branches take rs2 as the second operand
  assign use_rs2 = (op.func == FN_OP) || (op.func == FN_BRANCH);
  assign a       = op.rs1_value;
  assign b       = use_rs2 ? op.rs2_value : op.imm;
  assign sub_en  = (op.func == FN_OP) && op.alt_bit;
  assign shamt   = b[SHAMT_W-1:0];
  assign sum     = sub_en ? (a - b) : (a + b);
  assign sr_ext  = $signed({op.alt_bit & a[XLEN-1], a}) >>> shamt;

  assign eq  = (a == b);
  assign lt  = ($signed(a) < $signed(b));
  assign ltu = (a < b);

  always_comb begin
    case (op.funct3)
      F3_ADD:  y = sum;
      F3_SLL:  y = a << shamt;
      F3_SLT:  y = {{(XLEN-1){1'b0}}, lt};
      F3_SLTU: y = {{(XLEN-1){1'b0}}, ltu};
      F3_XOR:  y = a ^ b;
      F3_SR:   y = sr_ext[XLEN-1:0];
      F3_OR:   y = a | b;
      default: y = a & b;
    endcase
  end

  assign alu = {y, eq, lt, ltu};

endmodule

`default_nettype wire

### design/rv32ex_ctrl.sv
`default_nettype none

module rv32ex_ctrl (
  input  rv32ex_pkg::op_t      op,
  input  rv32ex_pkg::alu_out_t alu,
  output rv32ex_pkg::res_t     res
);
  import rv32ex_pkg::*;

  logic [XLEN-1:0] addr;
  logic [XLEN-1:0] pc_rel;
  logic [XLEN-1:0] link;
  logic            cond;
  logic            cond_ok;

  assign addr   = op.rs1_value + op.imm;
  assign pc_rel = op.pc + op.imm;
  assign link   = op.pc + INSN_BYTES;

  always_comb begin
    cond_ok = 1'b1;
    case (op.funct3)
      F3_BEQ:  cond = alu.eq;
      F3_BNE:  cond = !alu.eq;
      F3_BLT:  cond = alu.lt;
      F3_BGE:  cond = !alu.lt;
      F3_BLTU: cond = alu.ltu;
      F3_BGEU: cond = !alu.ltu;
      default: begin
        cond    = 1'b0;
        cond_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    res = '0;
    res.status = ST_NORMAL;
    case (op.func)
      FN_LOAD: begin
        res.result = addr;
        case (op.funct3)
          F3_B: begin
            res.mem_width  = MW_BYTE;
            res.mem_signed = 1'b1;
          end
          F3_H: begin
            res.mem_width  = MW_HALF;
            res.mem_signed = 1'b1;
          end
          F3_W:  res.mem_width = MW_WORD;
          F3_BU: res.mem_width = MW_BYTE;
          F3_HU: res.mem_width = MW_HALF;
          default: begin
            res.result = '0;
            res.status = ST_ILLEGAL;
          end
        endcase
      end
      FN_OPIMM, FN_OP: res.result = alu.y;
      FN_AUIPC:        res.result = pc_rel;
      FN_STORE: begin
        if (op.funct3 <= F3_W) begin
          res.result    = addr;
          res.mem_width = op.funct3[1:0];
        end else begin
          res.status = ST_ILLEGAL;
        end
      end
      FN_LUI: res.result = op.imm;
      FN_BRANCH: begin
        if (cond_ok) begin
          res.branch_target = pc_rel;
          res.branch_taken  = cond;
        end else begin
          res.status = ST_ILLEGAL;
        end
      end
      FN_JALR: begin
        res.result        = link;
        res.branch_target = {addr[XLEN-1:1], 1'b0};
        res.branch_taken  = 1'b1;
      end
      FN_JAL: begin
        res.result        = link;
        res.branch_target = pc_rel;
        res.branch_taken  = 1'b1;
      end
      FN_FENCE: res.status = ST_NORMAL;
      FN_SYSTEM: begin
        case (op.sys_op)
          SYS_EBREAK:        res.status = ST_BREAK;
          SYS_ECALL:         res.status = ST_ECALL;
          SYS_SRET, SYS_MRET: res.status = ST_TRET;
          SYS_WFI:           res.status = ST_WFI;
          SYS_CSR:           res.result = op.imm;  // CSR data goes through as is
          default:           res.status = ST_ILLEGAL;
        endcase
      end
      default: res.status = ST_ILLEGAL;
    endcase
  end

endmodule

`default_nettype wire

### design/rv32ex_fwd_dummy_guard.sv
`default_nettype none

// Holds one beat of the result channel: loads when the downstream side can take
// a new beat, and tells the stage in front whether it may move.
module rv32ex_out_reg (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   load,
  input  rv32ex_pkg::res_t      res_next,
  input  wire                   res_ready,
  output logic                  res_valid,
  output rv32ex_pkg::res_t      res,
  output logic                  can_load
);
  import rv32ex_pkg::*;

  assign can_load = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
